>>> hw/rtl/ring_buffer_deque_core_assert.svh
// Assertion macros for the ring buffer deque core.
// Included by the RTL files that carry concurrent checks; needs no package.
`ifndef RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`define RING_BUFFER_DEQUE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset
`define RBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset
`define RBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define RBD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hw/rtl/rbd_pkg.sv
// Shared types and constants for the ring buffer deque core.
// No dependencies; imported by every RTL module of the block.
package rbd_pkg;

  // Default sizing of the ring store
  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed field widths of the command and result transfers
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned RDATA_W  = 32;
  localparam int unsigned FIDX_W   = 10;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OCC_W    = 11;

  // Command opcodes
  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_READ       = 3'd4,
    OP_SEARCH     = 3'd5,
    OP_CLEAR      = 3'd6
  } rbd_op_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_RANGE = 3'd3,
    ST_MISS  = 3'd4
  } rbd_status_e;

  // One command transfer
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    position;
  } rbd_cmd_t;

  // One result transfer
  typedef struct packed {
    logic [RDATA_W-1:0]  read_data;
    logic [FIDX_W-1:0]   found_index;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } rbd_res_t;

endpackage

>>> hw/rtl/rbd_store.sv
// Ring store: single-port-write, single-port-read synchronous RAM with a registered read port.
// Depends on rbd_pkg for default sizing.
module rbd_store import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [DATA_WIDTH-1:0] wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/rbd_ctrl.sv
// Deque controller: head pointer, element count, command decode and search walk.
// Depends on rbd_pkg and drives the rbd_store ports; checks via the assert header.
`include "ring_buffer_deque_core_assert.svh"
module rbd_ctrl import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  rbd_cmd_t              cmd_i,
  output logic                  busy,
  output logic                  done_o,
  output rbd_res_t              res_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [DATA_WIDTH-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [DATA_WIDTH-1:0] mem_rdata_i
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_SEARCH = 2'b10
  } rbd_state_e;

  rbd_state_e            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         cmp_idx_q, cmp_idx_d;
  logic [DATA_WIDTH-1:0] key_q, key_d;
  logic                  done_q, done_d;
  logic                  rd_ok_q, rd_ok_d;
  rbd_status_e           status_q, status_d;
  logic [AW-1:0]         fidx_q, fidx_d;

  logic                  accept;
  logic                  go_search;
  logic                  is_full;
  logic                  is_empty;
  logic                  in_range;
  logic [DATA_WIDTH-1:0] val_w;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         head_inc;
  logic [CW-1:0]         idx_next_c;

  // Modular add of a logical offset below DEPTH onto a physical slot
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  assign busy     = (state_q == S_SEARCH);
  assign accept   = start && !busy;
  assign is_full  = (cnt_q == FULL_C);
  assign is_empty = (cnt_q == '0);
  assign in_range = (CMPW'(cmd_i.position) < CMPW'(cnt_q));
  assign val_w    = DATA_WIDTH'(cmd_i.value);
  assign head_dec = (head_q == '0) ? LAST : head_q - AW'(1);
  assign head_inc = (head_q == LAST) ? '0 : head_q + AW'(1);
  assign idx_next_c = CW'(cmp_idx_q) + CW'(1);
  assign go_search  = accept && (cmd_i.opcode == OP_SEARCH) && !is_empty;

  // Command decode and search walk
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    cmp_idx_d   = cmp_idx_q;
    key_d       = key_q;
    done_d      = 1'b0;
    rd_ok_d     = 1'b0;
    status_d    = status_q;
    fidx_d      = fidx_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = head_q;
    mem_wdata_o = val_w;
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          fidx_d   = '0;
          unique case (rbd_op_e'(cmd_i.opcode))
            OP_PUSH_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = wrap_add(head_q, cnt_q[AW-1:0]);
                cnt_d       = cnt_q + CW'(1);
              end
            end
            OP_PUSH_FRONT: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = head_dec;
                head_d      = head_dec;
                cnt_d       = cnt_q + CW'(1);
              end
            end
            OP_POP_BACK: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - CW'(1);
              end
            end
            OP_POP_FRONT: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                head_d = head_inc;
                cnt_d  = cnt_q - CW'(1);
              end
            end
            OP_READ: begin
              if (in_range) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = wrap_add(head_q, AW'(cmd_i.position));
                rd_ok_d     = 1'b1;
              end else begin
                status_d = ST_RANGE;
              end
            end
            OP_SEARCH: begin
              key_d = val_w;
              if (is_empty) begin
                status_d = ST_MISS;
              end else begin
                // first element read now, compared next cycle
                done_d      = 1'b0;
                mem_re_o    = 1'b1;
                mem_raddr_o = head_q;
                cmp_idx_d   = '0;
                state_d     = S_SEARCH;
              end
            end
            OP_CLEAR: begin
              head_d = '0;
              cnt_d  = '0;
            end
            default: begin
              // unused opcode: no state change, status ok
            end
          endcase
        end
      end
      S_SEARCH: begin
        // read data holds element cmp_idx_q; fetch the next one on a miss
        if (mem_rdata_i == key_q) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          fidx_d   = cmp_idx_q;
          state_d  = S_IDLE;
        end else if (idx_next_c == cnt_q) begin
          done_d   = 1'b1;
          status_d = ST_MISS;
          fidx_d   = '0;
          state_d  = S_IDLE;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = wrap_add(head_q, idx_next_c[AW-1:0]);
          cmp_idx_d   = idx_next_c[AW-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      rd_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      rd_ok_q <= rd_ok_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    key_q     <= key_d;
    status_q  <= status_d;
    fidx_q    <= fidx_d;
  end

  // Result transfer; count is already the post-operation value in the strobe cycle
  assign done_o            = done_q;
  assign res_o.read_data   = rd_ok_q ? RDATA_W'(mem_rdata_i) : '0;
  assign res_o.found_index = FIDX_W'(fidx_q);
  assign res_o.status      = status_q;
  assign res_o.occupancy   = OCC_W'(cnt_q);

  // Checks
  `RBD_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= FULL_C, "count above depth")
  `RBD_ASSERT_IMP(a_search_idx, clk_i, rst_ni, busy, CW'(cmp_idx_q) < cnt_q, "search past tail")
  `RBD_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, mem_we_o, !mem_re_o, "store read and write together")
  `RBD_ASSERT_IMP(a_no_done_busy, clk_i, rst_ni, busy, !done_q, "result during search walk")
  `RBD_ASSERT_NXT(a_one_cycle, clk_i, rst_ni, accept && !go_search, done_q, "missing result")

endmodule

>>> hw/rtl/ring_buffer_deque_core.sv
// Top level of the ring buffer deque core.
// Depends on rbd_pkg, rbd_store and rbd_ctrl.
//
// Usage:
//   A command (opcode, value, position) is transferred at a rising edge with start high
//   and busy low. Exactly one result per command appears on res_o for one cycle, marked
//   by done_o; the receiver takes it at the edge ending that cycle and cannot stall it.
//   Push, pop, read, clear and unused opcodes: result in the cycle after the transfer,
//   busy stays low, so one command per cycle is sustained.
//   Search: busy rises the cycle after the transfer while the store is walked from the
//   front, one element per cycle through its read port. A match at logical index k ends
//   the walk with found_index k; a miss ends it after the last element, and an empty deque
//   gives a miss the cycle after the transfer. A new command is taken in the result cycle.
//   Occupancy in the result is the element count after the command.
//   Reset clears head pointer, count and state; the store itself is not cleared, and
//   clear only resets the pointers. No clearing pass is needed after reset.
module ring_buffer_deque_core import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  rbd_cmd_t cmd_i,
  output logic     busy,
  output logic     done_o,
  output rbd_res_t res_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // Pointer, count and command sequencing
  rbd_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .done_o      (done_o),
    .res_o       (res_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Element storage
  rbd_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
